[src/trem_pkg.sv]
// ----------------------------------------------------------------------------
// trem_pkg
// shared types, constants and step codes for the tremolo core
// ----------------------------------------------------------------------------
package trem_pkg;

    localparam int LFO_DECIMATION = 10;
    localparam int DEC_W          = $clog2(LFO_DECIMATION + 1);

    localparam int DEPTH_W  = 15;
    localparam int RATE_W   = 14;
    localparam int CFG_W    = 15;
    localparam int SAMPLE_W = 16;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 15'd16383;
    localparam logic [RATE_W-1:0]  RATE_LOW    = 14'd1000;
    localparam logic [RATE_W-1:0]  RATE_HIGH   = 14'd10000;
    // k = 2 * 1530 * rate
    localparam logic [11:0]        RATE_SCALE2 = 12'd3060;
    localparam logic [31:0]        K_RESET     = 32'd15300000;

    localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
    localparam logic [31:0] AGC_BIAS  = 32'd1610612736;
    localparam logic [31:0] OSC_START = 32'd1518270939;
    localparam logic [31:0] LFO_NORM  = 32'd23170;
    localparam logic [31:0] RND_HALF  = 32'h0000_8000;

    localparam logic CFG_DEPTH = 1'b0;
    localparam logic CFG_RATE  = 1'b1;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [31:0]        k;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    typedef enum logic [3:0] {
        ST_KK,
        ST_CIP,
        ST_KQ,
        ST_CQ,
        ST_KIP,
        ST_Y1SQ,
        ST_Y2SQ,
        ST_Y1AGC,
        ST_Y2AGC,
        ST_LFO,
        ST_DEPTH,
        ST_OUT
    } t_step;

endpackage

[src/tremolo_with_agc_oscillator_core.sv]
// ----------------------------------------------------------------------------
// tremolo_with_agc_oscillator_core
// tremolo: audio word times depth times a gain-controlled quadrature lfo
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one signed q15 audio word in, m_axis one signed q15 word
//   out per input word. depth and rate_mhz are written through the cfg port
//   (index 0 depth, index 1 rate in millihertz, clamped to 1000..10000);
//   the user writes them only while the core is idle; it is not enforced.
//   every product is formed in one shared 32x32 multiplier, each with an
//   operand select state and then a write back state. a word that advances
//   the lfo takes twelve products; the other nine words of every ten take
//   two products.
//   the lfo advances on the first word after reset and then every tenth.
//   o_s_axis_tready is high only while no word is in work.
//   a finished word sits in the output register; the next input word may be
//   taken meanwhile, and its result waits until the receiver takes the old.
//   reset (synchronous, active low) restores the oscillator start point,
//   clears the held lfo value and restores the register defaults.
// ----------------------------------------------------------------------------
module tremolo_with_agc_oscillator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tdata: sample_in[15:0]
    input  logic [trem_pkg::SAMPLE_W-1:0]     i_s_axis_tdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: sample_out[15:0]
    output logic [trem_pkg::SAMPLE_W-1:0]     o_m_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [trem_pkg::CFG_W-1:0]        i_cfg_wdata
);
    import trem_pkg::*;

    t_cfg cfg;

    t_state r_state, n_state;
    t_step  r_step,  n_step;
    logic [DEC_W-1:0] r_dec;

    logic [31:0] r_ip, r_q, r_c, r_t, r_y1, r_y2, r_agc;
    logic [15:0] r_lfo, r_fx, r_x, r_y;
    logic [15:0] r_out_data;
    logic        r_out_valid;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_prod;
    logic [31:0]        q31;
    logic [31:0]        pow_sum;
    logic [32:0]        rnd_sum;
    logic [31:0]        rnd_sat;
    logic               s_accept;
    logic               out_load;

    trem_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    trem_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load        = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    assign q31 = mul_prod[62:31];

    // round y1 to its upper half, saturating only on positive overflow
    assign rnd_sum = {r_ip[31], r_ip} + {1'b0, RND_HALF};
    assign rnd_sat = (!rnd_sum[32] && rnd_sum[31]) ? 32'h7FFF_FFFF : rnd_sum[31:0];

    // operand select for the shared multiplier
    always_comb begin
        case (r_step)
            ST_KK:    begin mul_a = cfg.k;  mul_b = cfg.k;  end
            ST_CIP:   begin mul_a = r_c;    mul_b = r_ip;   end
            ST_KQ:    begin mul_a = cfg.k;  mul_b = r_q;    end
            ST_CQ:    begin mul_a = r_c;    mul_b = r_q;    end
            ST_KIP:   begin mul_a = cfg.k;  mul_b = r_ip;   end
            ST_Y1SQ:  begin mul_a = r_y1;   mul_b = r_y1;   end
            ST_Y2SQ:  begin mul_a = r_y2;   mul_b = r_y2;   end
            ST_Y1AGC: begin mul_a = r_y1;   mul_b = r_agc;  end
            ST_Y2AGC: begin mul_a = r_y2;   mul_b = r_agc;  end
            ST_LFO: begin
                mul_a = {{16{rnd_sat[31]}}, rnd_sat[31:16]};
                mul_b = LFO_NORM;
            end
            ST_DEPTH: begin
                mul_a = {17'd0, cfg.depth};
                mul_b = {{16{r_lfo[15]}}, r_lfo};
            end
            ST_OUT: begin
                mul_a = {{16{r_x[15]}}, r_x};
                mul_b = {{16{r_fx[15]}}, r_fx};
            end
            default:  begin mul_a = '0;     mul_b = '0;     end
        endcase
    end

    assign pow_sum = r_t + q31;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_ISSUE;
                    n_step  = (r_dec >= DEC_W'(LFO_DECIMATION - 1)) ? ST_KK : ST_DEPTH;
                end
            end
            S_ISSUE: n_state = S_WRITE;
            S_WRITE: begin
                if (r_step == ST_OUT) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ISSUE;
                    n_step  = t_step'(r_step + 4'd1);
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_KK;
            r_dec       <= DEC_W'(LFO_DECIMATION);
            r_ip        <= OSC_START;
            r_q         <= '0;
            r_lfo       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (s_accept) begin
                if (r_dec >= DEC_W'(LFO_DECIMATION - 1)) begin
                    r_dec <= '0;
                end else begin
                    r_dec <= r_dec + 1'b1;
                end
            end
            if (r_state == S_WRITE) begin
                case (r_step)
                    ST_Y1AGC: r_ip  <= {q31[30:0], 1'b0};
                    ST_Y2AGC: r_q   <= {q31[30:0], 1'b0};
                    ST_LFO:   r_lfo <= mul_prod[29:14];
                    default:  r_lfo <= r_lfo;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath work registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_x <= i_s_axis_tdata;
        end
        if (r_state == S_WRITE) begin
            case (r_step)
                ST_KK:    r_c   <= ONE_Q31 - {1'b0, q31[31:1]};
                ST_CIP:   r_t   <= q31;
                ST_KQ:    r_y1  <= r_t + q31;
                ST_CQ:    r_t   <= q31;
                ST_KIP:   r_y2  <= r_t - q31;
                ST_Y1SQ:  r_t   <= q31;
                ST_Y2SQ:  r_agc <= AGC_BIAS - {pow_sum[31], pow_sum[31:1]};
                ST_DEPTH: r_fx  <= mul_prod[30:15];
                ST_OUT:   r_y   <= mul_prod[30:15];
                default:  r_t   <= r_t;
            endcase
        end
        if (out_load) begin
            r_out_data <= r_y;
        end
    end

    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tvalid = r_out_valid;

endmodule

[src/trem_mul.sv]
// ----------------------------------------------------------------------------
// trem_mul
// shared 32 x 32 signed multiplier with a registered product
// ----------------------------------------------------------------------------
module trem_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_prod
);

    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

[src/trem_cfg.sv]
// ----------------------------------------------------------------------------
// trem_cfg
// configuration registers: depth, and the oscillator coefficient k from rate
// ----------------------------------------------------------------------------
module trem_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [trem_pkg::CFG_W-1:0]    i_cfg_wdata,
    output trem_pkg::t_cfg                o_cfg
);
    import trem_pkg::*;

    logic [DEPTH_W-1:0] r_depth;
    logic [31:0]        r_k;
    logic [RATE_W-1:0]  rate_raw;
    logic [RATE_W-1:0]  rate_sat;
    logic [25:0]        k_prod;

    assign rate_raw = i_cfg_wdata[RATE_W-1:0];

    always_comb begin
        if (rate_raw < RATE_LOW) begin
            rate_sat = RATE_LOW;
        end else if (rate_raw > RATE_HIGH) begin
            rate_sat = RATE_HIGH;
        end else begin
            rate_sat = rate_raw;
        end
    end

    assign k_prod = {12'd0, rate_sat} * {14'd0, RATE_SCALE2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_RESET;
            r_k     <= K_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEPTH: r_depth <= i_cfg_wdata[DEPTH_W-1:0];
                CFG_RATE:  r_k     <= {6'd0, k_prod};
                default:   r_depth <= r_depth;
            endcase
        end
    end

    assign o_cfg.depth = r_depth;
    assign o_cfg.k     = r_k;

endmodule

[tb/tremolo_with_agc_oscillator_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tremolo_with_agc_oscillator_core_test
// self-checking bench for the tremolo core with its gain-controlled lfo
// ----------------------------------------------------------------------------
// words go in on s_axis and come back on m_axis. a bit-true model of the
// quadrature oscillator, its gain correction, the decimated lfo update and
// the depth scaling predicts every output word. corner words run first under
// reset, saturating and extreme register settings, then random phases with
// fresh depth and rate, random gaps on the sender and random stalls on the
// receiver, and some phases with no idling at all.
// ----------------------------------------------------------------------------
module tremolo_with_agc_oscillator_core_test;
    import trem_pkg::*;

    class tremolo_gain_model;
        logic [DEPTH_W-1:0]  depth;
        logic [RATE_W-1:0]   rate;
        logic [31:0]         coef_k;
        logic [31:0]         coef_c;
        logic [31:0]         osc_i;
        logic [31:0]         osc_q;
        logic [15:0]         lfo_held;
        int                  lfo_count;
        int                  word_count;
        logic [SAMPLE_W-1:0] expected_words[$];

        function new();
            depth      = DEPTH_RESET;
            osc_i      = OSC_START;
            osc_q      = '0;
            lfo_held   = '0;
            lfo_count  = LFO_DECIMATION;
            word_count = 0;
            apply_cfg(CFG_RATE, 15'd5000);
        endfunction

        // q1.31 product, arithmetic shift, wrapped to 32 bits
        static function logic [31:0] q31_mul(logic [31:0] a, logic [31:0] b);
            longint p;
            p = longint'($signed(a)) * longint'($signed(b));
            p = p >>> 31;
            return p[31:0];
        endfunction

        function void apply_cfg(logic idx, logic [CFG_W-1:0] val);
            logic [RATE_W-1:0] r;
            if (idx == CFG_DEPTH) begin
                depth = val[DEPTH_W-1:0];
            end else begin
                r = val[RATE_W-1:0];
                if (r < RATE_LOW) begin
                    r = RATE_LOW;
                end else if (r > RATE_HIGH) begin
                    r = RATE_HIGH;
                end
                rate   = r;
                coef_k = r * RATE_SCALE2;
                coef_c = ONE_Q31 - (q31_mul(coef_k, coef_k) >> 1);
            end
        endfunction

        function logic [15:0] advance_lfo();
            logic [31:0] y1;
            logic [31:0] y2;
            logic [31:0] pw;
            logic [31:0] agc;
            longint      r;
            y1  = q31_mul(coef_c, osc_i) + q31_mul(coef_k, osc_q);
            y2  = q31_mul(coef_c, osc_q) - q31_mul(coef_k, osc_i);
            pw  = q31_mul(y1, y1) + q31_mul(y2, y2);
            pw  = {pw[31], pw[31:1]};
            agc = AGC_BIAS - pw;
            y1  = q31_mul(y1, agc) << 1;
            y2  = q31_mul(y2, agc) << 1;
            osc_i = y1;
            osc_q = y2;
            // round to 16 bits with saturation, then normalize by 1/0.707
            r = longint'($signed(y1)) + longint'(RND_HALF);
            if (r > 2147483647) begin
                r = 2147483647;
            end
            r = r >>> 16;
            r = (r * longint'(LFO_NORM)) >>> 14;
            return r[15:0];
        endfunction

        function void take_sample(logic [SAMPLE_W-1:0] x);
            longint fx;
            longint y;
            if (lfo_count >= LFO_DECIMATION - 1) begin
                lfo_held  = advance_lfo();
                lfo_count = 0;
            end else begin
                lfo_count++;
            end
            fx = (longint'(depth) * longint'($signed(lfo_held))) >>> 15;
            fx = longint'($signed(fx[15:0]));
            y  = (longint'($signed(x)) * fx) >>> 15;
            expected_words.push_back(y[SAMPLE_W-1:0]);
        endfunction

        function bit take_word(logic [SAMPLE_W-1:0] got, output string why);
            logic [SAMPLE_W-1:0] want;
            word_count++;
            if (expected_words.size() == 0) begin
                why = $sformatf("word %0d: %h arrived with nothing pending", word_count, got);
                return 1'b0;
            end
            want = expected_words.pop_front();
            if (got !== want) begin
                why = $sformatf("word %0d: sample_out %h, want %h", word_count, got, want);
                return 1'b0;
            end
            why = "";
            return 1'b1;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic [SAMPLE_W-1:0] i_s_axis_tdata  = '0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [SAMPLE_W-1:0] o_m_axis_tdata;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic                i_cfg_we        = 1'b0;
    logic                i_cfg_index     = CFG_DEPTH;
    logic [CFG_W-1:0]    i_cfg_wdata     = '0;

    tremolo_gain_model gain_model = new();
    int                errors     = 0;
    bit                idle_on    = 1'b1;
    int                rx_hold    = 0;

    logic [SAMPLE_W-1:0] corner_words[7] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001,
                                             16'hFFFF, 16'h5555, 16'hAAAA};

    tremolo_with_agc_oscillator_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    task automatic report_error(input string msg);
        errors++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic send_word(input logic [SAMPLE_W-1:0] w);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < 30) begin
            gap = gap_length();
        end
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= w;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        gain_model.take_sample(w);
    endtask

    // stop sending and let every pending word come back
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (gain_model.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gain_model.apply_cfg(idx, val);
        @(posedge i_clk);
    endtask

    // receiver with random stalls
    always @(posedge i_clk) begin
        if (rx_hold == 0 && idle_on && $urandom_range(0, 99) < 20) begin
            rx_hold = gap_length();
        end
        if (rx_hold != 0) begin
            rx_hold--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        string why;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (!gain_model.take_word(o_m_axis_tdata, why)) begin
                report_error(why);
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] depth_val;
        logic [CFG_W-1:0] rate_val;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner words under reset settings, then low rate clamp, then high
        foreach (corner_words[i]) send_word(corner_words[i]);
        settle();
        cfg_write(CFG_DEPTH, 15'h7FFF);
        cfg_write(CFG_RATE, 15'd0);
        foreach (corner_words[i]) send_word(corner_words[i]);
        settle();
        cfg_write(CFG_DEPTH, 15'h0000);
        cfg_write(CFG_RATE, 15'h7FFF);
        foreach (corner_words[i]) send_word(corner_words[i]);
        settle();

        for (int p = 0; p < 13; p++) begin
            case ($urandom_range(0, 7))
                0:       depth_val = 15'h0000;
                1:       depth_val = 15'h7FFF;
                default: depth_val = CFG_W'($urandom_range(0, 32767));
            endcase
            if (p == 0) begin
                depth_val = 15'h7FFF;
            end
            // keep the lfo fast most of the time so it swings through zero
            if (p % 4 == 3) begin
                rate_val = CFG_W'($urandom_range(0, 32767));
            end else if ($urandom_range(0, 1) == 0) begin
                rate_val = 15'd10000;
            end else begin
                rate_val = CFG_W'($urandom_range(9500, 10000));
            end
            cfg_write(CFG_DEPTH, depth_val);
            cfg_write(CFG_RATE, rate_val);
            idle_on = (p % 3 != 1);
            for (int n = 0; n < 93; n++) begin
                send_word(SAMPLE_W'($urandom()));
                if ($urandom_range(0, 199) == 0) begin
                    settle();
                end
            end
            settle();
        end
        cfg_write(CFG_RATE, 15'd1000);
        for (int n = 0; n < 20; n++) begin
            send_word(SAMPLE_W'($urandom()));
        end
        settle();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
src/trem_pkg.sv
src/trem_mul.sv
src/trem_cfg.sv
src/tremolo_with_agc_oscillator_core.sv
tb/tremolo_with_agc_oscillator_core_test.sv
